>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the symbol codec.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_PROP(label, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/u2s_pkg.sv
// Shared types, mode codes and helper functions of the symbol codec.
// Depends on nothing; used by every module of the block.
package u2s_pkg;

	// Input transaction payload
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_end;
	} in_t;

	// Output transaction payload
	typedef struct packed {
		logic [15:0] out_value;
		logic        out_last;
		logic        out_error;
	} out_t;

	// Work command from the front end to the back end
	typedef struct packed {
		logic [15:0] value;   // code unit, word, or symbol source
		logic        expand;  // send value as sixteen symbols
		logic        error;   // partial group error result
	} cmd_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic head_valid;
		logic full;
	} q_stat_t;

	localparam logic [1:0] MODE_UNITS   = 2'd0;
	localparam logic [1:0] MODE_SYMBOLS = 2'd1;
	localparam logic [1:0] MODE_WORDS   = 2'd2;

	localparam logic [7:0] SYM_ONE  = 8'h65;
	localparam logic [7:0] SYM_ZERO = 8'h45;
	localparam logic [3:0] SYM_LAST = 4'hF;

	// Count leading ones of a lead byte (0 to 8)
	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

>>> rtl/core/u2s_front.sv
// Front end: mode register, decode state and per-byte classification.
// Depends on u2s_pkg; pushes work commands into u2s_queue.
module u2s_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  u2s_pkg::in_t     in_data,
	input  u2s_pkg::q_stat_t q_stat,
	output logic             push,
	output u2s_pkg::cmd_t    push_cmd
);

	logic [1:0]  mode_q;
	logic [2:0]  pending_q;
	logic [15:0] acc_q;
	logic [3:0]  count_q;

	logic [2:0]    pending_n;
	logic [15:0]   acc_n;
	logic [3:0]    count_n;
	logic          emit;
	u2s_pkg::cmd_t cmd;
	logic          accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;
	assign push_cmd = cmd;

	always_comb begin
		logic [3:0] len_m1;
		logic [7:0] b;
		b         = in_data.in_byte;
		len_m1    = u2s_pkg::lead_ones(b) - 4'd1;
		pending_n = pending_q;
		acc_n     = acc_q;
		count_n   = count_q;
		emit      = 1'b0;
		cmd       = '0;
		cmd.expand = (mode_q == u2s_pkg::MODE_SYMBOLS);
		case (mode_q)
			u2s_pkg::MODE_UNITS, u2s_pkg::MODE_SYMBOLS: begin
				if (pending_q == 3'd0) begin
					if (!b[7]) begin
						// plain byte is a code unit by itself
						acc_n     = '0;
						emit      = 1'b1;
						cmd.value = {8'h00, b};
					end else begin
						acc_n     = {10'h000, b[5:0]};
						pending_n = len_m1[2:0];
						if (pending_n == 3'd0) begin
							emit      = 1'b1;
							cmd.value = acc_n;
							acc_n     = '0;
						end
					end
				end else begin
					acc_n     = {acc_q[9:0], b[5:0]};
					pending_n = pending_q - 3'd1;
					if (pending_n == 3'd0) begin
						emit      = 1'b1;
						cmd.value = acc_n;
						acc_n     = '0;
					end
				end
				// string ends mid-sequence: flush the partial value
				if (in_data.in_end && pending_n != 3'd0) begin
					emit      = 1'b1;
					cmd.value = acc_n;
					acc_n     = '0;
					pending_n = 3'd0;
				end
			end
			u2s_pkg::MODE_WORDS: begin
				acc_n   = {acc_q[14:0], b == u2s_pkg::SYM_ONE};
				count_n = count_q + 4'd1;
				if (count_n == 4'd0) begin
					emit      = 1'b1;
					cmd.value = acc_n;
					acc_n     = '0;
				end else if (in_data.in_end) begin
					emit      = 1'b1;
					cmd.value = '0;
					cmd.error = 1'b1;
					acc_n     = '0;
					count_n   = 4'd0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= u2s_pkg::MODE_UNITS;
			pending_q <= '0;
			acc_q     <= '0;
			count_q   <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				pending_q <= pending_n;
				acc_q     <= acc_n;
				count_q   <= count_n;
			end
		end
	end

endmodule

>>> rtl/core/u2s_queue.sv
// Short command queue between the front and back ends.
// Depends on u2s_pkg for the command and status types.
module u2s_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2s_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output u2s_pkg::cmd_t    head_cmd,
	output u2s_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	u2s_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head_cmd          = mem_q[rd_ptr_q];
	assign q_stat.head_valid = (count_q != '0);
	assign q_stat.full       = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/u2s_back.sv
// Back end: turns queued commands into output transactions.
// Depends on u2s_pkg; drains u2s_queue into a registered output stage.
module u2s_back (
	input  logic             clk,
	input  logic             arst_n,
	input  u2s_pkg::q_stat_t q_stat,
	input  u2s_pkg::cmd_t    head_cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output u2s_pkg::out_t    out_data
);

	logic          out_valid_q;
	u2s_pkg::out_t out_data_q;
	logic [3:0]    sym_idx_q;

	logic          load;
	logic          last_sym;
	u2s_pkg::out_t res;

	assign load      = !out_valid_q || out_ready;
	assign last_sym  = (sym_idx_q == u2s_pkg::SYM_LAST);
	assign pop       = load && q_stat.head_valid && (!head_cmd.expand || last_sym);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		res = '0;
		if (head_cmd.expand) begin
			// most significant bit first
			res.out_value = head_cmd.value[~sym_idx_q] ?
				{8'h00, u2s_pkg::SYM_ONE} : {8'h00, u2s_pkg::SYM_ZERO};
			res.out_last  = last_sym;
		end else begin
			res.out_value = head_cmd.value;
			res.out_last  = 1'b1;
			res.out_error = head_cmd.error;
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_stat.head_valid) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sym_idx_q   <= '0;
		end else if (load) begin
			out_valid_q <= q_stat.head_valid;
			if (q_stat.head_valid && head_cmd.expand) begin
				sym_idx_q <= last_sym ? 4'd0 : sym_idx_q + 4'd1;
			end
		end
	end

endmodule

>>> rtl/core/utf8_to_ucs2_symbol_codec.sv
// UTF-8 to UCS-2 symbol codec, top level; uses u2s_pkg, u2s_front, u2s_queue, u2s_back.
// Each command passes through the queue and then the registered output stage.
// Throughput, while results are taken: one byte per cycle in modes 0 and 2; in mode 1
// each code unit goes out as sixteen symbols, one per cycle from the back end's symbol
// counter, while the front end queues up to QUEUE_DEPTH - 1 commands behind the one
// under expansion. Reset selects mode 0 and clears all control state, but not the data registers.
`include "assert_macros.svh"

module utf8_to_ucs2_symbol_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	// configuration: mode register
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata,
	// input byte channel
	input  logic          in_valid,
	output logic          in_ready,
	input  u2s_pkg::in_t  in_data,
	// result channel
	output logic          out_valid,
	input  logic          out_ready,
	output u2s_pkg::out_t out_data
);

	logic             push;
	logic             pop;
	u2s_pkg::cmd_t    push_cmd;
	u2s_pkg::cmd_t    head_cmd;
	u2s_pkg::q_stat_t q_stat;

	// Front end: hold the mode, decode bytes, push at most one command per byte
	u2s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Queue: decouple decode from the symbol expansion
	u2s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	// Back end: advance through symbols or forward units and words
	u2s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Never push into a full queue or pop an empty one
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && q_stat.full)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !q_stat.head_valid)
	// An error result is a lone zero value that closes its transaction
	`ASSERT_PROP(a_err_form, clk, arst_n, (out_valid && out_data.out_error) |-> (out_data.out_last && out_data.out_value == 16'h0000))
	// Only symbol expansion yields results that are not last
	`ASSERT_PROP(a_sym_form, clk, arst_n, (out_valid && !out_data.out_last) |-> (out_data.out_value == 16'h0065 || out_data.out_value == 16'h0045))

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_to_ucs2_symbol_codec: directed script, then random strings.
// Depends on u2s_pkg for the payload types and mode codes; needs only the RTL.

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 8;       // cycles for in-flight bytes to drain after the last result
	localparam int PHASE_ITEMS = 26; // random bytes per mode phase, at the least
	localparam int WAIT_MAX = 17;

	// One directed transaction; a fixed row carries its single result typed in
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  b;
		logic        last_byte;
		logic        fixed;
		logic [15:0] value;
		logic        error;
	} script_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	logic  [1:0] cfg_wdata = 2'd0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	u2s_pkg::in_t  in_data = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	u2s_pkg::out_t out_data;

	// Predictor state: mode register, continuation bytes left, accumulator, symbols seen
	logic [1:0]  codec_mode = u2s_pkg::MODE_UNITS;
	logic [2:0]  cont_left = 3'd0;
	logic [15:0] shift_acc = 16'h0000;
	logic [3:0]  sym_seen = 4'd0;

	u2s_pkg::out_t owed_units[$];     // results due from the block, oldest first
	int   in_taken = 0;
	int   out_taken = 0;
	int   items_sent = 0;
	int   mismatches = 0;
	int   cycle_count = 0;
	int   in_calm = 0;
	int   out_calm = 0;

	// Typed-in result of the directed row currently offered
	logic        row_fixed = 1'b0;
	logic [15:0] row_value = 16'h0000;
	logic        row_error = 1'b0;

	script_row_t script [21] = '{
		// plain bytes at both ends of the ASCII range
		'{u2s_pkg::MODE_UNITS,   8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0},
		// stray continuation bytes taken as one-byte sequences
		'{u2s_pkg::MODE_UNITS,   8'h80, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'hBF, 1'b0, 1'b1, 16'h003F, 1'b0},
		// two- and three-byte characters
		'{u2s_pkg::MODE_UNITS,   8'hC3, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'hA9, 1'b0, 1'b1, 16'h00E9, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'hAC, 1'b0, 1'b1, 16'h20AC, 1'b0},
		// lead 0xFF opens an eight-byte sequence; the string ends inside it
		'{u2s_pkg::MODE_UNITS,   8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'h00, 1'b1, 1'b1, 16'h0FC0, 1'b0},
		// continuation bytes are not checked
		'{u2s_pkg::MODE_UNITS,   8'hE0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_UNITS,   8'h7F, 1'b0, 1'b0, 16'h0000, 1'b0},
		// symbol expansion, whole and cut short
		'{u2s_pkg::MODE_SYMBOLS, 8'h41, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_SYMBOLS, 8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_SYMBOLS, 8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
		// partial symbol groups at the end of a string flag an error
		'{u2s_pkg::MODE_WORDS,   8'h65, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_WORDS,   8'h45, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{u2s_pkg::MODE_WORDS,   8'h00, 1'b1, 1'b1, 16'h0000, 1'b1},
		'{u2s_pkg::MODE_WORDS,   8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1}
	};

	utf8_to_ucs2_symbol_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// Count of leading ones of a byte, 0 to 8
	function automatic int lead_run(input logic [7:0] b);
		int n;
		n = 0;
		while (n < 8 && b[7 - n]) n++;
		return n;
	endfunction

	task automatic queue_result(input logic [15:0] v, input logic er);
		u2s_pkg::out_t r;
		r = '{out_value: v, out_last: 1'b0, out_error: er};
		owed_units.push_back(r);
	endtask

	// A finished code unit: one result in unit mode, sixteen e/E symbols otherwise
	task automatic queue_unit(input logic [15:0] u);
		if (codec_mode == u2s_pkg::MODE_UNITS) begin
			queue_result(u, 1'b0);
		end else begin
			for (int i = 15; i >= 0; i--)
				queue_result(u[i] ? {8'h00, u2s_pkg::SYM_ONE} : {8'h00, u2s_pkg::SYM_ZERO},
					1'b0);
		end
	endtask

	// Advance the predicted codec state by one byte and queue what it yields
	task automatic decode_byte(input u2s_pkg::in_t it);
		int            owed_prior;
		u2s_pkg::out_t r;
		owed_prior = owed_units.size();
		if (codec_mode == u2s_pkg::MODE_UNITS || codec_mode == u2s_pkg::MODE_SYMBOLS) begin
			if (cont_left == 3'd0) begin
				if (!it.in_byte[7]) begin
					shift_acc = 16'h0000;
					queue_unit({8'h00, it.in_byte});
				end else begin
					shift_acc = {10'd0, it.in_byte[5:0]};
					cont_left = 3'(lead_run(it.in_byte) - 1);
					if (cont_left == 3'd0) begin
						queue_unit(shift_acc);
						shift_acc = 16'h0000;
					end
				end
			end else begin
				// bits shifted past the top of the accumulator are lost
				shift_acc = {shift_acc[9:0], it.in_byte[5:0]};
				cont_left = cont_left - 3'd1;
				if (cont_left == 3'd0) begin
					queue_unit(shift_acc);
					shift_acc = 16'h0000;
				end
			end
			// string ends mid-sequence: flush the partial value, drop the rest
			if (it.in_end && cont_left != 3'd0) begin
				queue_unit(shift_acc);
				shift_acc = 16'h0000;
				cont_left = 3'd0;
			end
		end else if (codec_mode == u2s_pkg::MODE_WORDS) begin
			shift_acc = {shift_acc[14:0], it.in_byte == u2s_pkg::SYM_ONE};
			sym_seen = sym_seen + 4'd1;
			if (sym_seen == 4'd0) begin
				queue_result(shift_acc, 1'b0);
				shift_acc = 16'h0000;
			end else if (it.in_end) begin
				queue_result(16'h0000, 1'b1);
				shift_acc = 16'h0000;
				sym_seen = 4'd0;
			end
		end
		// mark the final result of this byte
		if (owed_units.size() > owed_prior) begin
			r = owed_units.pop_back();
			r.out_last = 1'b1;
			owed_units.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input u2s_pkg::out_t want,
			input u2s_pkg::out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t (%s): expected value %h last %b error %b, got value %h last %b error %b",
				$realtime, what, want.out_value, want.out_last, want.out_error,
				got.out_value, got.out_last, got.out_error);
	endtask

	// Wait count for one transaction; now and then hold a stretch with no waits at all
	task automatic draw_wait(inout int calm, output int cycles);
		if (calm > 0) begin
			calm--;
			cycles = 0;
		end else if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(10, 40);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, WAIT_MAX);
		end
	endtask

	// Sample both channels at the rising edge, ahead of any register update
	always @(posedge clk) begin
		int            held;
		u2s_pkg::out_t want;
		u2s_pkg::out_t fixed_r;
		if (arst_n) begin
			cycle_count++;
			if (in_valid && in_ready) begin
				held = owed_units.size();
				decode_byte(in_data);
				// a directed row with a typed-in result replaces the predicted one
				if (row_fixed) begin
					while (owed_units.size() > held) void'(owed_units.pop_back());
					fixed_r = '{out_value: row_value, out_last: 1'b1, out_error: row_error};
					owed_units.push_back(fixed_r);
				end
				in_taken++;
			end
			if (out_valid && out_ready) begin
				if (owed_units.size() == 0) begin
					report_mismatch("no result due", '0, out_data);
				end else begin
					want = owed_units.pop_front();
					if (out_data.out_value !== want.out_value
							|| out_data.out_last !== want.out_last
							|| out_data.out_error !== want.out_error)
						report_mismatch("field differs", want, out_data);
				end
				out_taken++;
			end
		end
	end

	// Stop a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Result side: stall a random number of cycles before taking each transaction
	initial begin
		int stall;
		int target;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			draw_wait(out_calm, stall);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			target = out_taken + 1;
			do @(negedge clk); while (out_taken < target);
		end
	end

	// Offer one byte after a random gap and hold it until the transaction completes.
	// Valid stays high at return; the next call either replaces the payload or drops valid.
	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		int target;
		draw_wait(in_calm, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, in_end: e};
		target = in_taken + 1;
		do @(negedge clk); while (in_taken < target);
		items_sent++;
	endtask

	// Drop valid, let every due result arrive, then let stray bytes settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (owed_units.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		codec_mode = m;
	endtask

	// A UTF-8 string: mostly well-formed characters, some stray and noise bytes,
	// and now and then a last character cut short by the end of the string
	task automatic send_text();
		logic [7:0] text[$];
		logic [7:0] lead;
		int         chars;
		int         kind;
		int         n;
		chars = $urandom_range(1, 6);
		n = 1;
		for (int c = 0; c < chars; c++) begin
			kind = $urandom_range(0, 19);
			n = 1;
			if (kind < 8) begin
				lead = 8'($urandom_range(0, 127));
			end else if (kind < 12) begin
				lead = 8'hC0 | 8'($urandom_range(0, 31));
				n = 2;
			end else if (kind < 15) begin
				lead = 8'hE0 | 8'($urandom_range(0, 15));
				n = 3;
			end else if (kind == 15) begin
				lead = 8'hF0 | 8'($urandom_range(0, 7));
				n = 4;
			end else if (kind == 16) begin
				lead = 8'($urandom_range(248, 255));
				n = lead_run(lead);
			end else if (kind == 17) begin
				lead = 8'($urandom_range(128, 191));
			end else begin
				lead = 8'($urandom);
			end
			text.push_back(lead);
			for (int j = 1; j < n; j++) begin
				if ($urandom_range(0, 9) == 0)
					text.push_back(8'($urandom));
				else
					text.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		end
		if (n > 1 && $urandom_range(0, 3) == 0) void'(text.pop_back());
		foreach (text[i]) send_byte(text[i], i == text.size() - 1);
	endtask

	// Symbol stream: mostly whole groups of sixteen, sometimes a ragged length
	task automatic send_symbols();
		int         n;
		int         r;
		logic [7:0] sym;
		if ($urandom_range(0, 3) == 0)
			n = $urandom_range(1, 40);
		else
			n = 16 * $urandom_range(1, 2);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 19);
			sym = (r < 9) ? u2s_pkg::SYM_ONE : (r < 18) ? u2s_pkg::SYM_ZERO : 8'($urandom);
			send_byte(sym, i == n - 1);
		end
	endtask

	initial begin
		logic [1:0] m;
		int         start;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed script; switch mode only when the row asks for another one
		foreach (script[i]) begin
			if (script[i].mode != codec_mode) set_mode(script[i].mode);
			row_fixed = script[i].fixed;
			row_value = script[i].value;
			row_error = script[i].error;
			send_byte(script[i].b, script[i].last_byte);
		end
		wait_idle();
		row_fixed = 1'b0;

		// Random phases; the first three visit every mode, the rest pick at random
		for (int p = 0; p < 8; p++) begin
			if (p == 0)
				m = u2s_pkg::MODE_UNITS;
			else if (p == 1)
				m = u2s_pkg::MODE_WORDS;
			else if (p == 2)
				m = u2s_pkg::MODE_SYMBOLS;
			else
				m = 2'($urandom_range(0, 2));
			set_mode(m);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if (m == u2s_pkg::MODE_WORDS)
					send_symbols();
				else
					send_text();
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
